>>> hdl/ldls_pkg.sv
// Package for the LDL' symmetric solver: item and command types, APB constants,
// and the saturating Q32.32 helper functions. No dependencies.
package ldls_pkg;

    localparam int DEF_MAX_ORDER = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QW            = 2;
    localparam int MUL_PARTS     = 4;
    localparam int DIV_STEPS     = 96;
    localparam int HARD_LIMIT    = 32;

    localparam int          APB_AW      = 3;
    localparam logic [2:0]  ADDR_ORDER  = 3'd0;
    localparam logic [5:0]  ORDER_RESET = 6'd1;

    localparam logic [1:0] ACT_LOAD_M = 2'd0;
    localparam logic [1:0] ACT_LOAD_R = 2'd1;
    localparam logic [1:0] ACT_SOLVE  = 2'd2;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         index;
        logic signed [63:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] solution;
        logic [4:0]         row;
        logic               last;
        logic               status;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_LOAD_M,
        CMD_LOAD_R,
        CMD_SOLVE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [9:0]  index;
        logic [63:0] value;
    } t_cmd;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
        logic        err;
    } t_alu_rsp;

    typedef struct packed {
        logic [63:0] val;
        logic        ovf;
    } t_sat;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic t_sat sat_add(input logic [63:0] a, input logic [63:0] b);
        t_sat        r;
        logic [63:0] s;
        s     = a + b;
        r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
        r.val = r.ovf ? (a[63] ? SIGN_BIT : POS_MAX) : s;
        return r;
    endfunction

    function automatic t_sat sat_sub(input logic [63:0] a, input logic [63:0] b);
        t_sat        r;
        logic [63:0] d;
        d     = a - b;
        r.ovf = (a[63] != b[63]) && (d[63] != a[63]);
        r.val = r.ovf ? (a[63] ? SIGN_BIT : POS_MAX) : d;
        return r;
    endfunction

    // Apply the sign to a magnitude and clip to the signed 64-bit range.
    function automatic t_sat apply_sign(input logic neg, input logic [63:0] mag,
                                        input logic over);
        t_sat r;
        if (neg) begin
            r.ovf = over || (mag > SIGN_BIT);
            r.val = r.ovf ? SIGN_BIT : (64'd0 - mag);
        end else begin
            r.ovf = over || (mag > POS_MAX);
            r.val = r.ovf ? POS_MAX : mag;
        end
        return r;
    endfunction

endpackage

>>> hdl/ldls_front.sv
// Front end: accepts input items, drops unused actions and out-of-range loads,
// and queues commands for the engine. Depends on ldls_pkg.
module ldls_front import ldls_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    localparam int PACKED = MAX_ORDER * (MAX_ORDER + 1) / 2;

    t_cmd          r_q_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wp;
    logic [QW-1:0] r_rp;
    logic [QW:0]   r_count;
    logic          w_full;
    logic          w_keep;
    logic          w_push;
    t_cmd          w_cmd;

    assign w_full      = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_in_stall  = w_full;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q_mem[r_rp];

    always_comb begin
        w_cmd.index = i_in_data.index;
        w_cmd.value = i_in_data.value;
        w_cmd.kind  = CMD_SOLVE;
        w_keep      = 1'b0;
        unique case (i_in_data.action)
            ACT_LOAD_M: begin
                w_cmd.kind = CMD_LOAD_M;
                w_keep     = 32'(i_in_data.index) < 32'(PACKED);
            end
            ACT_LOAD_R: begin
                w_cmd.kind = CMD_LOAD_R;
                w_keep     = 32'(i_in_data.index) < 32'(MAX_ORDER);
            end
            ACT_SOLVE: begin
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign w_push = i_in_valid && !w_full && w_keep;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (QW+1)'(w_push) - (QW+1)'(i_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

>>> hdl/ldls_alu.sv
// Shared multi-cycle arithmetic unit: Q32.32 multiply from four 32x32 partial
// products and a restoring divider, one quotient bit a cycle. Depends on ldls_pkg.
module ldls_alu import ldls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_MFIN,
        A_DIV,
        A_DFIN
    } t_state;

    t_state       r_state;
    logic         r_neg;
    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic [6:0]   r_cnt;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [95:0]  r_dvd;
    logic [63:0]  r_rem;
    logic [63:0]  r_q;
    logic         r_over;
    logic         r_done;
    logic [63:0]  r_res;
    logic         r_err;

    logic [63:0]  w_amag;
    logic [63:0]  w_bmag;
    logic [31:0]  w_ma;
    logic [31:0]  w_mb;
    logic [63:0]  w_pp;
    logic [1:0]   w_prev;
    logic [127:0] w_pp_sh;
    logic [64:0]  w_rem2;
    logic         w_ge;
    t_sat         w_mfin;
    t_sat         w_dfin;

    assign w_amag = mag64(i_req.a);
    assign w_bmag = mag64(i_req.b);

    // One 32x32 multiplier, operand halves picked by the step count.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin w_ma = r_x[31:0];  w_mb = r_y[31:0];  end
            2'd1:    begin w_ma = r_x[31:0];  w_mb = r_y[63:32]; end
            2'd2:    begin w_ma = r_x[63:32]; w_mb = r_y[31:0];  end
            default: begin w_ma = r_x[63:32]; w_mb = r_y[63:32]; end
        endcase
    end

    assign w_pp   = {32'd0, w_ma} * {32'd0, w_mb};
    assign w_prev = 2'(r_cnt - 7'd1);

    always_comb begin
        case (w_prev)
            2'd0:    w_pp_sh = {64'd0, r_pp};
            2'd3:    w_pp_sh = {r_pp, 64'd0};
            default: w_pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    assign w_rem2 = {r_rem, r_dvd[95]};
    assign w_ge   = (w_rem2 >= {1'b0, r_y});
    assign w_mfin = apply_sign(r_neg, r_acc[95:32], |r_acc[127:96]);
    assign w_dfin = apply_sign(r_neg, r_q, r_over);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    r_done <= i_req.start && (i_req.op == ALU_DIV) && (w_bmag == '0);
                    if (i_req.start) begin
                        r_neg <= i_req.a[63] ^ i_req.b[63];
                        r_x   <= w_amag;
                        r_y   <= w_bmag;
                        r_cnt <= '0;
                        if (i_req.op == ALU_MUL) begin
                            r_acc   <= '0;
                            r_state <= A_MUL;
                        end else if (w_bmag == '0) begin
                            // zero pivot: flag and clip towards the numerator's sign
                            r_err  <= 1'b1;
                            r_res  <= (w_amag == '0) ? 64'd0 :
                                      (i_req.a[63] ? SIGN_BIT : POS_MAX);
                        end else begin
                            r_dvd   <= {w_amag, 32'd0};
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_over  <= 1'b0;
                            r_state <= A_DIV;
                        end
                    end
                end
                A_MUL: begin
                    r_done <= 1'b0;
                    r_pp   <= w_pp;
                    if (r_cnt != '0) begin
                        r_acc <= r_acc + w_pp_sh;
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(MUL_PARTS)) begin
                        r_state <= A_MFIN;
                    end
                end
                A_MFIN: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                    if (r_acc[95:32] == '0) begin
                        r_res <= '0;
                        r_err <= 1'b0;
                    end else begin
                        r_res <= w_mfin.val;
                        r_err <= w_mfin.ovf;
                    end
                end
                A_DIV: begin
                    r_done <= 1'b0;
                    r_rem  <= w_ge ? 64'(w_rem2 - {1'b0, r_y}) : w_rem2[63:0];
                    r_over <= r_over | r_q[63];
                    r_q    <= {r_q[62:0], w_ge};
                    r_dvd  <= {r_dvd[94:0], 1'b0};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(DIV_STEPS - 1)) begin
                        r_state <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    r_done  <= 1'b1;
                    r_res   <= w_dfin.val;
                    r_err   <= w_dfin.ovf;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.err  = r_err;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == A_IDLE))
        else $error("operation started while unit busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

    a_mul_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_MUL) |-> (r_cnt <= 7'(MUL_PARTS)))
        else $error("multiply step count overrun");

endmodule

>>> hdl/ldls_engine.sv
// Back end: matrix and right-hand-side memories, the factor/solve sequencer and
// the output register. Uses ldls_alu through ports. Depends on ldls_pkg.
module ldls_engine import ldls_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [5:0] i_order,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output t_alu_req  o_req,
    input  t_alu_rsp  i_rsp,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int PACKED = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int AW     = (PACKED > 1) ? $clog2(PACKED) : 1;
    localparam int RW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW     = $clog2(MAX_ORDER + 1);
    localparam int TW     = 2 * CW + 1;
    localparam int LIM    = (MAX_ORDER < HARD_LIMIT) ? MAX_ORDER : HARD_LIMIT;

    typedef enum logic [4:0] {
        S_IDLE, S_FJ, S_FI, S_FK, S_RD1, S_RD2, S_RD3, S_MUL1, S_MUL1W, S_MUL2,
        S_MUL2W, S_FIN_RD, S_FIN_RD2, S_FIN, S_DIVW, S_FW_I, S_FW_BI, S_FW_J,
        S_FW_RD, S_FW_MW, S_DG_I, S_DG_RD, S_DG_W, S_BW_I, S_BW_BI, S_BW_J,
        S_BW_RD, S_BW_MW, S_OUT, S_OUT_RD
    } t_state;

    logic [63:0] r_mat [PACKED];
    logic [63:0] r_rhs [MAX_ORDER];
    logic [63:0] r_mrd;
    logic [63:0] r_brd;

    t_state      r_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_k;
    logic [63:0] r_v;
    logic [63:0] r_opa;
    logic [63:0] r_opb;
    logic [63:0] r_opc;
    logic [63:0] r_t;
    logic [63:0] r_bi;
    logic        r_err;
    logic        r_ov;
    t_out_item   r_out;

    logic [CW-1:0] w_row;
    logic [CW-1:0] w_col;
    logic [TW-1:0] w_tw;
    logic [TW-1:0] w_base;
    logic [AW-1:0] w_maddr;
    logic [AW-1:0] w_m_addr;
    logic [RW-1:0] w_b_addr;
    logic        w_m_we;
    logic        w_b_we;
    logic [63:0] w_m_wdata;
    logic [63:0] w_b_wdata;
    t_sat        w_sat;
    logic        w_sat_use;
    logic        w_err_set;
    logic [5:0]  w_n6;
    logic [CW-1:0] w_n_eff;
    logic        w_last;
    logic        w_out_free;
    logic        w_ov_set;
    logic        w_solve;

    // Effective order: clip to the store size and to the row field's range.
    assign w_n6    = (i_order > 6'(LIM)) ? 6'(LIM) : i_order;
    assign w_n_eff = CW'(w_n6);
    assign w_solve = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == CMD_SOLVE)
                     && (w_n_eff != '0);

    // Packed lower-triangle address row*(row+1)/2 + col.
    assign w_tw    = TW'(w_row);
    assign w_base  = (w_tw * (w_tw + TW'(1))) >> 1;
    assign w_maddr = AW'(w_base + TW'(w_col));

    assign w_last     = ((CW+1)'(r_i) + (CW+1)'(1)) == (CW+1)'(r_n);
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_ov_set   = (r_state == S_OUT_RD) && w_out_free;

    always_comb begin
        w_row      = r_j;
        w_col      = r_i;
        w_b_addr   = RW'(r_i);
        w_m_we     = 1'b0;
        w_b_we     = 1'b0;
        w_m_wdata  = i_cmd.value;
        w_b_wdata  = i_cmd.value;
        o_pop      = 1'b0;
        o_req      = '0;
        w_sat      = sat_sub(r_opa, i_rsp.res);
        w_sat_use  = 1'b0;
        w_m_addr   = w_maddr;
        unique case (r_state)
            S_IDLE: begin
                o_pop    = i_cmd_valid;
                w_m_addr = AW'(i_cmd.index);
                w_b_addr = RW'(i_cmd.index);
                w_m_we   = i_cmd_valid && (i_cmd.kind == CMD_LOAD_M);
                w_b_we   = i_cmd_valid && (i_cmd.kind == CMD_LOAD_R);
            end
            S_RD1: begin
                w_row = r_i;
                w_col = r_k;
            end
            S_RD2: begin
                w_col = r_k;
            end
            S_RD3: begin
                w_row = r_k;
                w_col = r_k;
            end
            S_MUL1: begin
                o_req = '{start: 1'b1, op: ALU_MUL, a: r_opa, b: r_opb};
            end
            S_MUL2: begin
                o_req = '{start: 1'b1, op: ALU_MUL, a: r_t, b: r_opc};
            end
            S_MUL2W: begin
                w_sat     = sat_add(r_v, i_rsp.res);
                w_sat_use = i_rsp.done;
            end
            S_FIN_RD2: begin
                w_row = r_i;
            end
            S_FIN: begin
                w_sat     = sat_sub(r_opa, r_v);
                w_sat_use = 1'b1;
                w_m_wdata = w_sat.val;
                if (r_i < r_j) begin
                    o_req = '{start: 1'b1, op: ALU_DIV, a: w_sat.val, b: r_mrd};
                end else begin
                    w_m_we = 1'b1;
                end
            end
            S_DIVW: begin
                w_m_we    = i_rsp.done;
                w_m_wdata = i_rsp.res;
            end
            S_FW_J: begin
                w_b_addr = RW'(r_j);
            end
            S_FW_RD: begin
                o_req = '{start: 1'b1, op: ALU_MUL, a: r_mrd, b: r_bi};
            end
            S_FW_MW: begin
                w_b_addr  = RW'(r_j);
                w_b_we    = i_rsp.done;
                w_b_wdata = w_sat.val;
                w_sat_use = i_rsp.done;
            end
            S_DG_I: begin
                w_row = r_i;
            end
            S_DG_RD: begin
                o_req = '{start: 1'b1, op: ALU_DIV, a: r_brd, b: r_mrd};
            end
            S_DG_W: begin
                w_b_we    = i_rsp.done;
                w_b_wdata = i_rsp.res;
            end
            S_BW_J: begin
                w_row    = r_i;
                w_col    = r_j - 1'b1;
                w_b_addr = RW'(r_j - 1'b1);
            end
            S_BW_RD: begin
                o_req = '{start: 1'b1, op: ALU_MUL, a: r_mrd, b: r_bi};
            end
            S_BW_MW: begin
                w_b_addr  = RW'(r_j - 1'b1);
                w_b_we    = i_rsp.done;
                w_b_wdata = w_sat.val;
                w_sat_use = i_rsp.done;
            end
            default: begin
            end
        endcase
    end

    assign w_err_set = (i_rsp.done && i_rsp.err) || (w_sat_use && w_sat.ovf);

    always_ff @(posedge i_clk) begin
        if (w_m_we) begin
            r_mat[w_m_addr] <= w_m_wdata;
        end
        r_mrd <= r_mat[w_m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            r_rhs[w_b_addr] <= w_b_wdata;
        end
        r_brd <= r_rhs[w_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // clear the run flag on a solve, else collect saturation and pivot errors
            r_err <= w_solve ? 1'b0 : (r_err | w_err_set);
            r_ov  <= w_ov_set || (r_ov && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (w_solve) begin
                        r_n     <= w_n_eff;
                        r_j     <= CW'(1);
                        r_state <= S_FJ;
                    end
                end
                S_FJ: begin
                    r_i     <= '0;
                    r_state <= (r_j < r_n) ? S_FI : S_FW_I;
                end
                S_FI: begin
                    r_v     <= '0;
                    r_k     <= '0;
                    r_state <= S_FK;
                end
                S_FK: begin
                    r_state <= (r_k < r_i) ? S_RD1 : S_FIN_RD;
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_opa   <= r_mrd;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_opb   <= r_mrd;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_opc   <= r_mrd;
                    r_state <= S_MUL1W;
                end
                S_MUL1W: begin
                    if (i_rsp.done) begin
                        r_t     <= i_rsp.res;
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_state <= S_MUL2W;
                end
                S_MUL2W: begin
                    if (i_rsp.done) begin
                        r_v     <= w_sat.val;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_FK;
                    end
                end
                S_FIN_RD: begin
                    r_state <= S_FIN_RD2;
                end
                S_FIN_RD2: begin
                    r_opa   <= r_mrd;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_i < r_j) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_FJ;
                    end
                end
                S_DIVW: begin
                    if (i_rsp.done) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FI;
                    end
                end
                S_FW_I: begin
                    if (((CW+1)'(r_i) + (CW+1)'(1)) < (CW+1)'(r_n)) begin
                        r_j     <= r_i + 1'b1;
                        r_state <= S_FW_BI;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_DG_I;
                    end
                end
                S_FW_BI: begin
                    r_bi    <= r_brd;
                    r_state <= S_FW_J;
                end
                S_FW_J: begin
                    if (r_j < r_n) begin
                        r_state <= S_FW_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FW_I;
                    end
                end
                S_FW_RD: begin
                    r_opa   <= r_brd;
                    r_state <= S_FW_MW;
                end
                S_FW_MW: begin
                    if (i_rsp.done) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_FW_J;
                    end
                end
                S_DG_I: begin
                    if (r_i < r_n) begin
                        r_state <= S_DG_RD;
                    end else begin
                        r_i     <= r_n - 1'b1;
                        r_state <= S_BW_I;
                    end
                end
                S_DG_RD: begin
                    r_state <= S_DG_W;
                end
                S_DG_W: begin
                    if (i_rsp.done) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DG_I;
                    end
                end
                S_BW_I: begin
                    if (r_i != '0) begin
                        r_j     <= r_i;
                        r_state <= S_BW_BI;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_BW_BI: begin
                    r_bi    <= r_brd;
                    r_state <= S_BW_J;
                end
                S_BW_J: begin
                    if (r_j != '0) begin
                        r_state <= S_BW_RD;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_BW_I;
                    end
                end
                S_BW_RD: begin
                    r_opa   <= r_brd;
                    r_state <= S_BW_MW;
                end
                S_BW_MW: begin
                    if (i_rsp.done) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_BW_J;
                    end
                end
                S_OUT: begin
                    r_state <= S_OUT_RD;
                end
                S_OUT_RD: begin
                    if (w_out_free) begin
                        r_out.solution <= r_brd;
                        r_out.row      <= 5'(r_i);
                        r_out.last     <= w_last;
                        r_out.status   <= r_err;
                        r_i            <= r_i + 1'b1;
                        r_state        <= w_last ? S_IDLE : S_OUT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_RD && w_out_free && w_last) |=> (r_state == S_IDLE))
        else $error("run did not end after its last word");

    a_solve_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_solve |=> !r_err)
        else $error("error flag not cleared at solve start");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.done |-> (r_state == S_MUL1W || r_state == S_MUL2W || r_state == S_DIVW
                        || r_state == S_FW_MW || r_state == S_DG_W
                        || r_state == S_BW_MW))
        else $error("arithmetic result arrived with nobody waiting");

endmodule

>>> hdl/ldl_symmetric_solver_core.sv
// Top level of the LDL' symmetric solver: APB order register, front end,
// command queue, sequencer and arithmetic unit. Depends on ldls_pkg and all ldls_ modules.
//
// Use: stream load items in (action 0 writes one packed lower-triangle word at
// index row*(row+1)/2+col, action 1 writes one right-hand-side word), then send
// a solve item (action 2). The solve factors M = L D L' in place and returns one
// solution word per row in ascending order, the final one marked by last; status
// carries the zero-pivot / saturation flag of the whole run on every word.
// Input channel: i_in_valid / o_in_stall, a transfer when valid is high and stall
// low. Loads pass through a four-entry queue, so the front end keeps
// taking loads while the engine works; the queue fills during a solve.
// Solve time is set by the shared arithmetic unit: each multiply sums four 32x32
// partial products and each divide makes one quotient bit a cycle. A solve of
// order n does n*(n+1)/2 divides. Output: o_out_valid / i_out_stall through
// one output register; while the receiver stalls, the word holds and the engine
// waits. Reset clears control state and sets order to 1; the stores are not
// cleared and must be loaded before use. Write order only while the block is idle.
module ldl_symmetric_solver_core import ldls_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    logic [5:0] r_order;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_pop;
    t_alu_req   w_req;
    t_alu_rsp   w_rsp;

    // APB: no wait states; only the order register exists.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ORDER) ? {26'd0, r_order} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_ORDER)) begin
            r_order <= pwdata[5:0];
        end
    end

    // Front: classify and queue; drops unused actions and loads out of range.
    ldls_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop       (w_pop)
    );

    // Back: memories plus the factor and substitution sequencer.
    ldls_engine #(
        .MAX_ORDER (MAX_ORDER)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_order     (r_order),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_req       (w_req),
        .i_rsp       (w_rsp),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Shared multiply / divide unit.
    ldls_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

endmodule

>>> test/tb_ldl_symmetric_solver_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for ldl_symmetric_solver_core: streams load and solve transfers,
// predicts every solution word in a scoreboard class. Depends on ldls_pkg and the core RTL.
module tb_ldl_symmetric_solver_core;
    import ldls_pkg::*;

    localparam int          PACKED      = 528;
    localparam int          RHS_DEPTH   = 32;
    localparam int          WATCH_LIMIT = 1000000;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [63:0] ONE_Q       = 64'h0000_0001_0000_0000;

    // Holds its own copy of both stores and the order register, solves the system
    // on every solve transfer with a nonzero order and queues the words the block must return.
    class solution_board;
        logic [63:0] mat [PACKED];
        logic [63:0] rhs [RHS_DEPTH];
        logic [5:0]  order;
        bit          flag;
        t_out_item   pending_words [$];
        int          faults;

        function new();
            order  = ORDER_RESET;
            flag   = 0;
            faults = 0;
            foreach (mat[i]) mat[i] = '0;
            foreach (rhs[i]) rhs[i] = '0;
        endfunction

        function int tri_ix(int r, int c);
            return r * (r + 1) / 2 + c;
        endfunction

        function logic [63:0] magn(logic [63:0] v);
            return v[63] ? (64'd0 - v) : v;
        endfunction

        function logic [63:0] clip(bit neg, logic [63:0] m, bit over);
            if (neg) begin
                if (over || m > SIGN_BIT) begin
                    flag = 1;
                    return SIGN_BIT;
                end
                return 64'd0 - m;
            end
            if (over || m > POS_MAX) begin
                flag = 1;
                return POS_MAX;
            end
            return m;
        endfunction

        function logic [63:0] add_q(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) begin
                flag = 1;
                return a[63] ? SIGN_BIT : POS_MAX;
            end
            return s;
        endfunction

        function logic [63:0] sub_q(logic [63:0] a, logic [63:0] b);
            logic [63:0] d;
            d = a - b;
            if (a[63] != b[63] && d[63] != a[63]) begin
                flag = 1;
                return a[63] ? SIGN_BIT : POS_MAX;
            end
            return d;
        endfunction

        function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, magn(a)} * {64'd0, magn(b)};
            if (p[95:32] == 64'd0) return 64'd0;
            return clip(a[63] ^ b[63], p[95:32], p[127:96] != 0);
        endfunction

        function logic [63:0] div_q(logic [63:0] a, logic [63:0] b);
            logic [95:0] q;
            logic [63:0] n;
            logic [63:0] d;
            n = magn(a);
            d = magn(b);
            if (d == 64'd0) begin
                // zero pivot: flag it, zero over zero stays zero
                flag = 1;
                if (n == 64'd0) return 64'd0;
                return a[63] ? SIGN_BIT : POS_MAX;
            end
            q = {n, 32'd0} / {32'd0, d};
            if (q == 96'd0) return 64'd0;
            return clip(a[63] ^ b[63], q[63:0], q[95:64] != 0);
        endfunction

        // Factor in place, then forward, diagonal and backward passes.
        function void solve_system(int n);
            logic [63:0] v;
            for (int j = 1; j < n; j++) begin
                for (int i = 0; i < j; i++) begin
                    v = '0;
                    for (int k = 0; k < i; k++)
                        v = add_q(v, mul_q(mul_q(mat[tri_ix(i, k)], mat[tri_ix(j, k)]),
                                           mat[tri_ix(k, k)]));
                    mat[tri_ix(j, i)] = div_q(sub_q(mat[tri_ix(j, i)], v), mat[tri_ix(i, i)]);
                end
                v = '0;
                for (int k = 0; k < j; k++)
                    v = add_q(v, mul_q(mul_q(mat[tri_ix(j, k)], mat[tri_ix(j, k)]),
                                       mat[tri_ix(k, k)]));
                mat[tri_ix(j, j)] = sub_q(mat[tri_ix(j, j)], v);
            end
            for (int i = 0; i + 1 < n; i++)
                for (int j = i + 1; j < n; j++)
                    rhs[j] = sub_q(rhs[j], mul_q(mat[tri_ix(j, i)], rhs[i]));
            for (int i = 0; i < n; i++)
                rhs[i] = div_q(rhs[i], mat[tri_ix(i, i)]);
            for (int i = n - 1; i > 0; i--)
                for (int j = i; j > 0; j--)
                    rhs[j-1] = sub_q(rhs[j-1], mul_q(mat[tri_ix(i, j-1)], rhs[i]));
        endfunction

        function void take_item(t_in_item it);
            t_out_item w;
            int        n;
            case (it.action)
                ACT_LOAD_M: if (it.index < PACKED) mat[it.index] = it.value;
                ACT_LOAD_R: if (it.index < RHS_DEPTH) rhs[it.index] = it.value;
                ACT_SOLVE: begin
                    n = (order > RHS_DEPTH) ? RHS_DEPTH : int'(order);
                    if (n != 0) begin
                        flag = 0;
                        solve_system(n);
                        for (int r = 0; r < n; r++) begin
                            w.solution = rhs[r];
                            w.row      = r[4:0];
                            w.last     = (r + 1 == n);
                            w.status   = flag;
                            pending_words.push_back(w);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void match_word(t_out_item got);
            t_out_item want;
            if (pending_words.size() == 0) begin
                if (faults < 10) $display("unexpected word: row %0d solution %h",
                                          got.row, got.solution);
                faults++;
                return;
            end
            want = pending_words.pop_front();
            if (got.solution !== want.solution || got.row !== want.row ||
                got.last !== want.last || got.status !== want.status) begin
                if (faults < 10)
                    $display({"mismatch: exp sol %h row %0d last %b st %b, ",
                              "got sol %h row %0d last %b st %b"},
                             want.solution, want.row, want.last, want.status,
                             got.solution, got.row, got.last, got.status);
                faults++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              o_in_stall;
    t_in_item          in_data;
    logic              o_out_valid;
    logic              out_stall;
    t_out_item         o_out_data;

    solution_board board;
    int            in_count;
    int            out_count;
    int            quiet_cycles;
    int            hold_left;
    bit            hold_done;
    bit            hold_req;
    int            real_items;

    ldl_symmetric_solver_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Sample both channels at the rising edge, before the block's registers move.
    // Any transfer or APB access clears the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                board.take_item(in_data);
                in_count++;
            end
            if (o_out_valid && !out_stall) begin
                board.match_word(o_out_data);
                out_count++;
            end
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (psel && penable)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stall, a calm stretch, and one long hold-off that lets the
    // input queue fill behind a blocked output word.
    always @(negedge i_clk) begin
        if (!hold_done && hold_req && o_out_valid) begin
            hold_left = 400;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (out_count >= 40 && out_count < 90) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 15);
        end
    end

    // Offer one transfer; enter and leave at a falling edge. Valid is held across
    // back-to-back transfers so it is never dropped and raised in the same step.
    task automatic send(logic [1:0] act, logic [9:0] ix, logic [63:0] val);
        if (in_count < 100 || in_count >= 180) begin
            while ($urandom_range(99) < 15) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid        <= 1'b1;
        in_data.action  <= act;
        in_data.index   <= ix;
        in_data.value   <= val;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and let the block drain, then allow a margin for queued loads.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_words.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_order(logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_ORDER;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.order = v[5:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Noise transfers: unused action or an index past the end of a store.
    task automatic send_noise();
        case ($urandom_range(2))
            0: send(ACT_UNUSED, 10'($urandom), rand64());
            1: send(ACT_LOAD_M, 10'($urandom_range(1023, PACKED)), rand64());
            default: send(ACT_LOAD_R, 10'($urandom_range(1023, RHS_DEPTH)), rand64());
        endcase
    endtask

    // Load an n-by-n system and solve it. Style 0 is diagonally dominant, style 1
    // raw 64-bit words, style 2 zeroes one diagonal word, style 3 skips some loads.
    task automatic run_system(int n, int style);
        longint      t;
        logic [63:0] v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (style == 1) begin
                    v = rand64();
                end else if (c == r) begin
                    t = (longint'(n) + longint'($urandom_range(1, 8))) <<< 32;
                    v = t + longint'($urandom);
                    if (style == 2 && r == n / 2) v = '0;
                end else begin
                    t = longint'($urandom_range(65535)) - 32768;
                    v = t <<< 16;
                end
                if (!(style == 3 && $urandom_range(3) == 0)) begin
                    send(ACT_LOAD_M, 10'(r * (r + 1) / 2 + c), v);
                    real_items++;
                end
                if ($urandom_range(99) < 6) send_noise();
            end
        end
        for (int r = 0; r < n; r++) begin
            t = longint'($urandom_range(400)) - 200;
            v = (style == 1) ? rand64() : ((t <<< 32) + longint'($urandom));
            if (!(style == 3 && $urandom_range(3) == 0)) begin
                send(ACT_LOAD_R, 10'(r), v);
                real_items++;
            end
        end
        send(ACT_SOLVE, 10'($urandom), rand64());
        real_items++;
        // repeated solve on the stored factors and solution
        if ($urandom_range(99) < 15) begin
            send(ACT_SOLVE, 10'($urandom), rand64());
            real_items++;
        end
    endtask

    initial begin
        int n_cur;
        board        = new();
        in_count     = 0;
        out_count    = 0;
        quiet_cycles = 0;
        hold_left    = 0;
        hold_done    = 0;
        hold_req     = 0;
        real_items   = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: value extremes, saturation, zero pivot, ignored transfers.
        write_order(32'd1);
        send(ACT_LOAD_M, 10'd0, ONE_Q);
        send(ACT_LOAD_R, 10'd0, POS_MAX);
        send(ACT_SOLVE, 10'd0, '0);
        send(ACT_LOAD_M, 10'd0, 64'd1);
        send(ACT_LOAD_R, 10'd0, SIGN_BIT);
        send(ACT_SOLVE, 10'd0, '0);
        send(ACT_LOAD_M, 10'd0, '0);
        send(ACT_LOAD_R, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(ACT_SOLVE, 10'd0, '0);
        send(ACT_LOAD_R, 10'd0, '0);
        send(ACT_SOLVE, 10'd0, '0);
        send(ACT_LOAD_M, 10'd0, 64'hFFFF_FFFF_0000_0000);
        send(ACT_LOAD_R, 10'd0, ONE_Q);
        send(ACT_SOLVE, 10'd1023, '1);
        send(ACT_SOLVE, 10'd0, '0);
        send(ACT_UNUSED, 10'd0, '1);
        send(ACT_LOAD_M, 10'd1023, '1);
        send(ACT_LOAD_R, 10'd32, '1);
        drain();
        write_order(32'd0);
        send(ACT_SOLVE, 10'd0, '0);
        drain();
        write_order(32'd2);
        run_system(2, 0);

        // Hold the receiver on the first word while loads keep coming behind it.
        hold_req = 1;
        for (int r = 0; r < 8; r++) send(ACT_LOAD_R, 10'(r), rand64());

        // Largest system, with an order above the limit; fills both stores.
        drain();
        write_order(32'd63);
        run_system(RHS_DEPTH, 0);

        real_items = 0;
        n_cur      = RHS_DEPTH;
        while (real_items < 330) begin
            if (n_cur == RHS_DEPTH || $urandom_range(99) < 30) begin
                drain();
                n_cur = ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
                write_order(32'(n_cur));
            end
            case ($urandom_range(9))
                0:       run_system(n_cur, 1);
                1:       run_system(n_cur, 2);
                2, 3:    run_system(n_cur, 3);
                default: run_system(n_cur, 0);
            endcase
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (board.faults == 0 && board.pending_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/ldls_pkg.sv
hdl/ldls_front.sv
hdl/ldls_alu.sv
hdl/ldls_engine.sv
hdl/ldl_symmetric_solver_core.sv
test/tb_ldl_symmetric_solver_core.sv
